FILE: sv/fraction_arith_reduce_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fraction arithmetic block.
// Each macro expands to a labeled concurrent assertion, or to nothing when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FRACTION_ARITH_REDUCE_ASSERT_SVH
`define FRACTION_ARITH_REDUCE_ASSERT_SVH
`ifndef SYNTHESIS
`define FAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FAR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/far_pkg.sv
// ---------------------------------------------------------------------------
// Fraction arithmetic package
// Widths, opcodes, controller states and command and status types.
// ---------------------------------------------------------------------------
`default_nettype none
package far_pkg;
  localparam int unsigned OpW = 16;
  localparam int unsigned ProdW = 2 * OpW;
  localparam int unsigned MagW = ProdW + 1;
  localparam int unsigned CntW = $clog2(MagW + 1);
  localparam int unsigned NumW = 33;
  localparam int unsigned DenW = 31;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_SIMP = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic div_sel_den;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

FILE: sv/fraction_arith_reduce.sv
// ---------------------------------------------------------------------------
// Fraction arithmetic with reduction
// One item at a time: products, signed sum, binary GCD and two restoring
// divisions. A zero numerator or denominator skips the GCD loop and both divisions.
// ---------------------------------------------------------------------------
`default_nettype none
`include "fraction_arith_reduce_assert.svh"
module fraction_arith_reduce (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [2:0]                       opcode_i,
  input  logic signed [far_pkg::OpW-1:0]   num_a_i,
  input  logic signed [far_pkg::OpW-1:0]   den_a_i,
  input  logic signed [far_pkg::OpW-1:0]   num_b_i,
  input  logic signed [far_pkg::OpW-1:0]   den_b_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [far_pkg::NumW-1:0]  res_num_o,
  output logic [far_pkg::DenW-1:0]         res_den_o,
  output logic                             status_o
);
  far_pkg::cmd_t cmd;
  far_pkg::sts_t sts;
  logic busy, in_fire, out_free, ov_q;

  assign in_ready_o = !busy;
  assign in_fire = in_valid_i && in_ready_o;
  assign out_free = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd.finish) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  logic signed [far_pkg::NumW-1:0] num_w;
  logic [far_pkg::DenW-1:0] den_w;
  logic st_w;
  logic signed [far_pkg::NumW-1:0] num_q;
  logic [far_pkg::DenW-1:0] den_q;
  logic st_q;

  always_ff @(posedge clk_i) begin
    if (cmd.finish) begin
      num_q <= num_w; den_q <= den_w; st_q <= st_w;
    end
  end

  assign res_num_o = num_q;
  assign res_den_o = den_q;
  assign status_o = st_q;

  far_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_fire_i(in_fire), .out_free_i(out_free),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  far_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .opcode_i(opcode_i),
    .num_a_i(num_a_i), .den_a_i(den_a_i), .num_b_i(num_b_i), .den_b_i(den_b_i),
    .sts_o(sts), .res_num_o(num_w), .res_den_o(den_w), .status_o(st_w)
  );

  `FAR_ASSERT_IMPL(a_no_load_busy, clk_i, rst_ni, busy, !cmd.load)
  `FAR_ASSERT_NEXT(a_finish_valid, clk_i, rst_ni, cmd.finish, out_valid_o)
  `FAR_ASSERT_IMPL(a_err_den, clk_i, rst_ni, out_valid_o && status_o, res_den_o == '0)
endmodule
`default_nettype wire

FILE: sv/far_ctrl.sv
// ---------------------------------------------------------------------------
// Fraction arithmetic controller
// Sequences operand products, GCD reduction and the two divisions.
// ---------------------------------------------------------------------------
`default_nettype none
module far_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            out_free_i,
  input  far_pkg::sts_t   sts_i,
  output far_pkg::cmd_t   cmd_o,
  output logic            busy_o
);
  far_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= far_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      far_pkg::ST_IDLE: if (in_fire_i) state_d = far_pkg::ST_MUL;
      far_pkg::ST_MUL:  state_d = far_pkg::ST_SUM;
      far_pkg::ST_SUM:  state_d = far_pkg::ST_GCD;
      far_pkg::ST_GCD: begin
        if (sts_i.special) state_d = far_pkg::ST_OUT;
        else if (sts_i.gcd_done) state_d = far_pkg::ST_DIVN;
      end
      far_pkg::ST_DIVN: if (sts_i.div_done) state_d = far_pkg::ST_DIVD;
      far_pkg::ST_DIVD: if (sts_i.div_done) state_d = far_pkg::ST_OUT;
      far_pkg::ST_OUT:  if (out_free_i) state_d = far_pkg::ST_IDLE;
      default:          state_d = far_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      far_pkg::ST_IDLE: cmd_o.load = in_fire_i;
      far_pkg::ST_MUL:  cmd_o.mul = 1'b1;
      far_pkg::ST_SUM:  cmd_o.sum = 1'b1;
      far_pkg::ST_GCD: begin
        cmd_o.gcd_step = !sts_i.special && !sts_i.gcd_done;
        cmd_o.div_start = sts_i.gcd_done && !sts_i.special;
      end
      far_pkg::ST_DIVN: begin
        cmd_o.div_step = !sts_i.div_done;
        cmd_o.div_start = sts_i.div_done;
        cmd_o.div_sel_den = sts_i.div_done;
      end
      far_pkg::ST_DIVD: begin
        cmd_o.div_step = !sts_i.div_done;
        cmd_o.div_sel_den = 1'b1;
      end
      far_pkg::ST_OUT:  cmd_o.finish = out_free_i;
      default:          cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != far_pkg::ST_IDLE);
endmodule
`default_nettype wire

FILE: sv/far_dp.sv
// ---------------------------------------------------------------------------
// Fraction arithmetic datapath
// Products, signed sum, binary GCD and a restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none
module far_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  far_pkg::cmd_t                    cmd_i,
  input  logic [2:0]                       opcode_i,
  input  logic signed [far_pkg::OpW-1:0]   num_a_i,
  input  logic signed [far_pkg::OpW-1:0]   den_a_i,
  input  logic signed [far_pkg::OpW-1:0]   num_b_i,
  input  logic signed [far_pkg::OpW-1:0]   den_b_i,
  output far_pkg::sts_t                    sts_o,
  output logic signed [far_pkg::NumW-1:0]  res_num_o,
  output logic [far_pkg::DenW-1:0]         res_den_o,
  output logic                             status_o
);
  localparam int unsigned W = far_pkg::OpW;
  localparam int unsigned P = far_pkg::ProdW;
  localparam int unsigned M = far_pkg::MagW;
  localparam int unsigned C = far_pkg::CntW;

  logic [2:0]   op_q;
  logic [W-1:0] ma_q, da_q, mb_q, db_q;
  logic         sa_q, sda_q, sb_q, sdb_q;
  logic [P-1:0] p1_q, p2_q, pd_q;
  logic         s1_q, s2_q, sd_q;
  logic [M-1:0] n_q, d_q, u_q, v_q, g_q;
  logic         nneg_q;
  logic [C-1:0] k_q;
  logic [M-1:0] quo_q, rem_q, dvd_q;
  logic [C-1:0] dcnt_q;
  logic [M-1:0] rn_q;
  logic         spec_q, err_q;
  logic [far_pkg::NumW-1:0] onum_q;
  logic [far_pkg::DenW-1:0] oden_q;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  logic [M-1:0] a1, a2, sum_mag, g_sh, rem_sh;
  logic         sum_neg, sub_op;
  logic [M-1:0] d_new;

  always_comb begin
    sub_op = (op_q == far_pkg::OP_SUB);
    a1 = {1'b0, p1_q};
    a2 = {1'b0, p2_q};
    if (s1_q == (s2_q ^ sub_op)) begin
      sum_mag = a1 + a2;
      sum_neg = s1_q;
    end else if (a1 >= a2) begin
      sum_mag = a1 - a2;
      sum_neg = s1_q;
    end else begin
      sum_mag = a2 - a1;
      sum_neg = s2_q ^ sub_op;
    end
    g_sh = u_q << k_q;
    rem_sh = {rem_q[M-2:0], dvd_q[M-1]};
    d_new = {1'b0, pd_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spec_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.sum) spec_q <= (d_new == '0) || (sum_mag == '0);
      if (cmd_i.div_start) dcnt_q <= C'(M);
      else if (cmd_i.div_step) dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      ma_q <= mag(num_a_i); sa_q <= num_a_i[W-1];
      da_q <= mag(den_a_i); sda_q <= den_a_i[W-1];
      mb_q <= mag(num_b_i); sb_q <= num_b_i[W-1];
      db_q <= mag(den_b_i); sdb_q <= den_b_i[W-1];
    end
    if (cmd_i.mul) begin
      unique case (op_q)
        far_pkg::OP_ADD, far_pkg::OP_SUB: begin
          p1_q <= ma_q * db_q; s1_q <= sa_q ^ sdb_q;
          p2_q <= mb_q * da_q; s2_q <= sb_q ^ sda_q;
          pd_q <= da_q * db_q; sd_q <= sda_q ^ sdb_q;
        end
        far_pkg::OP_MUL: begin
          p1_q <= ma_q * mb_q; s1_q <= sa_q ^ sb_q;
          p2_q <= '0; s2_q <= 1'b0;
          pd_q <= da_q * db_q; sd_q <= sda_q ^ sdb_q;
        end
        far_pkg::OP_DIV: begin
          p1_q <= ma_q * db_q; s1_q <= sa_q ^ sdb_q;
          p2_q <= '0; s2_q <= 1'b0;
          pd_q <= da_q * mb_q; sd_q <= sda_q ^ sb_q;
        end
        default: begin
          p1_q <= P'(ma_q); s1_q <= sa_q;
          p2_q <= '0; s2_q <= 1'b0;
          pd_q <= P'(da_q); sd_q <= sda_q;
        end
      endcase
    end
    if (cmd_i.sum) begin
      n_q <= sum_mag;
      d_q <= d_new;
      u_q <= sum_mag;
      v_q <= d_new;
      k_q <= '0;
      nneg_q <= sum_neg ^ sd_q;
      err_q <= (d_new == '0);
    end
    if (cmd_i.gcd_step) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1; v_q <= v_q >> 1; k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= (u_q - v_q) >> 1;
      end else begin
        v_q <= (v_q - u_q) >> 1;
      end
    end
    if (cmd_i.div_start) begin
      g_q <= cmd_i.div_sel_den ? g_q : g_sh;
      dvd_q <= cmd_i.div_sel_den ? d_q : n_q;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= g_q) begin
        rem_q <= rem_sh - g_q;
        quo_q <= {quo_q[M-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[M-2:0], 1'b0};
      end
      dvd_q <= dvd_q << 1;
    end
    if (cmd_i.div_start && cmd_i.div_sel_den) rn_q <= quo_q;
    if (sts_o.special && !cmd_i.finish) begin
      onum_q <= '0;
      oden_q <= err_q ? '0 : far_pkg::DenW'(1);
    end else if (sts_o.div_done && cmd_i.div_sel_den && !cmd_i.div_start) begin
      onum_q <= nneg_q ? far_pkg::NumW'(~rn_q + 1'b1) : far_pkg::NumW'(rn_q);
      oden_q <= far_pkg::DenW'(quo_q);
    end
  end

  assign sts_o.special = spec_q;
  assign sts_o.gcd_done = (u_q == '0) || (v_q == '0) || (u_q == v_q);
  assign sts_o.div_done = (dcnt_q == '0);
  assign res_num_o = onum_q;
  assign res_den_o = oden_q;
  assign status_o = err_q;
endmodule
`default_nettype wire
